### src/lzss_pkg.sv
// Shared types and constants of the LZSS stream decompressor.
package lzss_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int LEN_BIAS   = 2;
    localparam int FLAG_COUNT = 8;

    typedef logic [7:0]         t_byte;
    typedef logic [HIST_AW-1:0] t_hist_addr;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HDR_SHORT = 3'd1,
        ST_ARC_SIZE  = 3'd2,
        ST_BAD_REF   = 3'd3,
        ST_OUT_SIZE  = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_FLAG   = 5'b00010,
        PH_TOKEN  = 5'b00100,
        PH_PAIR   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_READ = 3'b010,
        SQ_EMIT = 3'b100
    } t_seq;

endpackage

### src/lzss_hist.sv
// History window memory: one write port, one registered read port.
module lzss_hist (
    input  logic                i_clk,
    input  logic                i_we,
    input  lzss_pkg::t_hist_addr i_waddr,
    input  lzss_pkg::t_byte     i_wdata,
    input  logic                i_re,
    input  lzss_pkg::t_hist_addr i_raddr,
    output lzss_pkg::t_byte     o_rdata
);
    import lzss_pkg::*;

    t_byte r_mem [HIST_DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/lzss_stream_decompressor.sv
// LZSS stream decompressor top level: header parse, token decode and copy sequencer.
//
// One compressed byte is taken per item. A literal loads its byte into the output register as
// it is accepted, and it shows in the cycle after. For the second byte of a back-reference pair
// of length L (2..17), each copied byte is read from the 4096-byte history memory (registered
// read) in SQ_READ and then written back and presented in SQ_EMIT, which waits for the output
// side. The input is not ready while a copy runs or while a result waits that the output
// side has not taken. Results leave through a one-item output register. The status of the
// stream rides on the last result of the item marked tlast, after which the block starts a new
// header; the history memory needs no clearing since only bytes of the current stream are read.
module lzss_stream_decompressor #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  lzss_pkg::t_byte       s_axis_tdata,   // in_byte
    input  logic                  s_axis_tlast,   // in_last
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output lzss_pkg::t_byte       m_axis_tdata,   // out_byte
    output logic [3:0]            m_axis_tuser,   // out_valid, status[2:0]
    output logic                  m_axis_tlast    // stream_end
);
    import lzss_pkg::*;

    localparam int SW = SIZE_WIDTH;

    t_seq             r_seq, n_seq;
    t_phase           r_phase, n_phase;
    logic [SW-1:0]    r_arc, n_arc;
    logic [SW-1:0]    r_orig, n_orig;
    logic [SW-1:0]    r_bytes_in, n_bytes_in;
    logic [SW-1:0]    r_bytes_out, n_bytes_out;
    t_byte            r_flag_bits, n_flag_bits;
    logic [3:0]       r_flags_left, n_flags_left;
    t_byte            r_pair_low, n_pair_low;
    t_status          r_err, n_err;
    logic [HIST_AW-1:0] r_dist, n_dist;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_last, n_last;

    logic             r_m_valid, n_m_valid;
    t_byte            r_m_byte, n_m_byte;
    logic             r_m_flag, n_m_flag;
    logic             r_m_last, n_m_last;
    t_status          r_m_status, n_m_status;

    logic             out_free;
    logic             acc;
    logic             go_copy;
    logic             clr;
    logic             ld;
    t_byte            ld_byte;
    logic             ld_flag;
    logic             ld_last;
    t_status          ld_status;
    logic [2:0]       hdr_idx;
    logic [SW-1:0]    hdr_val;
    logic [15:0]      word;
    logic [SW-1:0]    bin_inc;
    logic [SW-1:0]    bo_inc;
    logic [3:0]       left_dec;
    t_byte            copy_val;
    logic             size_hit;

    logic             hist_we;
    t_byte            hist_wdata;
    logic             hist_re;
    t_hist_addr       hist_raddr;
    t_byte            hist_rdata;

    function automatic t_phase f_after_token(logic [SW-1:0] nbo, logic [SW-1:0] orig,
                                             logic [3:0] left);
        t_phase ph;
        if (nbo >= orig) begin
            ph = PH_DONE;
        end else if (left == 4'd0) begin
            ph = PH_FLAG;
        end else begin
            ph = PH_TOKEN;
        end
        return ph;
    endfunction

    function automatic t_status f_status(t_phase ph, logic [SW-1:0] arc, logic [SW-1:0] bin,
                                         t_status err, logic [SW-1:0] bo, logic [SW-1:0] orig);
        t_status st;
        if (ph == PH_HEADER) begin
            st = ST_HDR_SHORT;
        end else if (arc != bin) begin
            st = ST_ARC_SIZE;
        end else if (err != ST_OK) begin
            st = err;
        end else if (bo != orig) begin
            st = ST_OUT_SIZE;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_seq == SQ_IDLE) && out_free;
    assign acc           = s_axis_tvalid && s_axis_tready;

    assign hdr_idx  = r_bytes_in[2:0];
    assign hdr_val  = SW'(32'(s_axis_tdata) << {hdr_idx[1:0], 3'b000});
    assign word     = {s_axis_tdata, r_pair_low};
    assign bin_inc  = (r_bytes_in != '1) ? r_bytes_in + 1'b1 : r_bytes_in;
    assign bo_inc   = r_bytes_out + 1'b1;
    assign left_dec = (r_flags_left != 4'd0) ? r_flags_left - 4'd1 : 4'd0;
    assign copy_val = (r_dist == '0) ? 8'h00 : hist_rdata;
    assign size_hit = bo_inc >= r_orig;
    assign hist_raddr = r_bytes_out[HIST_AW-1:0] - r_dist;

    always_comb begin
        n_seq        = r_seq;
        n_phase      = r_phase;
        n_arc        = r_arc;
        n_orig       = r_orig;
        n_bytes_in   = r_bytes_in;
        n_bytes_out  = r_bytes_out;
        n_flag_bits  = r_flag_bits;
        n_flags_left = r_flags_left;
        n_pair_low   = r_pair_low;
        n_err        = r_err;
        n_dist       = r_dist;
        n_cnt        = r_cnt;
        n_last       = r_last;
        go_copy      = 1'b0;
        clr          = 1'b0;
        ld           = 1'b0;
        ld_byte      = 8'h00;
        ld_flag      = 1'b0;
        ld_last      = 1'b0;
        ld_status    = ST_OK;
        hist_we      = 1'b0;
        hist_wdata   = 8'h00;
        hist_re      = 1'b0;

        case (r_seq)
            SQ_IDLE: begin
                if (acc) begin
                    n_bytes_in = bin_inc;
                    case (r_phase)
                        PH_HEADER: begin
                            if (!hdr_idx[2]) begin
                                n_arc = r_arc | hdr_val;
                            end else begin
                                n_orig = r_orig | hdr_val;
                            end
                            if (hdr_idx == 3'd7) begin
                                n_phase = (n_orig == '0) ? PH_DONE : PH_FLAG;
                            end
                        end
                        PH_FLAG: begin
                            n_flag_bits  = s_axis_tdata;
                            n_flags_left = 4'(FLAG_COUNT);
                            n_phase      = PH_TOKEN;
                        end
                        PH_TOKEN: begin
                            if (r_flag_bits[0]) begin
                                hist_we      = 1'b1;
                                hist_wdata   = s_axis_tdata;
                                ld           = 1'b1;
                                ld_byte      = s_axis_tdata;
                                ld_flag      = 1'b1;
                                n_bytes_out  = bo_inc;
                                n_flag_bits  = r_flag_bits >> 1;
                                n_flags_left = left_dec;
                                n_phase      = f_after_token(bo_inc, r_orig, left_dec);
                            end else begin
                                n_pair_low = s_axis_tdata;
                                n_phase    = PH_PAIR;
                            end
                        end
                        PH_PAIR: begin
                            if (SW'(word[15:4]) > r_bytes_out) begin
                                n_err   = ST_BAD_REF;
                                n_phase = PH_DONE;
                            end else begin
                                n_dist  = word[15:4];
                                n_cnt   = 5'(word[3:0]) + 5'(LEN_BIAS);
                                n_last  = s_axis_tlast;
                                n_seq   = SQ_READ;
                                go_copy = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (s_axis_tlast && !go_copy) begin
                        ld        = 1'b1;
                        ld_last   = 1'b1;
                        ld_status = f_status(n_phase, n_arc, n_bytes_in, n_err, n_bytes_out,
                                             n_orig);
                        clr       = 1'b1;
                    end
                end
            end
            SQ_READ: begin
                hist_re = 1'b1;
                n_seq   = SQ_EMIT;
            end
            SQ_EMIT: begin
                if (out_free) begin
                    hist_we     = 1'b1;
                    hist_wdata  = copy_val;
                    ld          = 1'b1;
                    ld_byte     = copy_val;
                    ld_flag     = 1'b1;
                    n_bytes_out = bo_inc;
                    if (r_cnt == 5'd1 || size_hit) begin
                        if (r_cnt != 5'd1) begin
                            n_err = ST_OUT_SIZE;
                        end
                        n_flag_bits  = r_flag_bits >> 1;
                        n_flags_left = left_dec;
                        n_phase      = f_after_token(bo_inc, r_orig, left_dec);
                        n_seq        = SQ_IDLE;
                        if (r_last) begin
                            ld_last   = 1'b1;
                            ld_status = f_status(n_phase, r_arc, r_bytes_in, n_err, bo_inc,
                                                 r_orig);
                            clr       = 1'b1;
                        end
                    end else begin
                        n_cnt = r_cnt - 5'd1;
                        n_seq = SQ_READ;
                    end
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase

        if (clr) begin
            n_phase      = PH_HEADER;
            n_arc        = '0;
            n_orig       = '0;
            n_bytes_in   = '0;
            n_bytes_out  = '0;
            n_flag_bits  = 8'h00;
            n_flags_left = 4'd0;
            n_pair_low   = 8'h00;
            n_err        = ST_OK;
        end

        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_byte   = r_m_byte;
        n_m_flag   = r_m_flag;
        n_m_last   = r_m_last;
        n_m_status = r_m_status;
        if (ld) begin
            n_m_valid  = 1'b1;
            n_m_byte   = ld_byte;
            n_m_flag   = ld_flag;
            n_m_last   = ld_last;
            n_m_status = ld_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= SQ_IDLE;
            r_phase      <= PH_HEADER;
            r_arc        <= '0;
            r_orig       <= '0;
            r_bytes_in   <= '0;
            r_bytes_out  <= '0;
            r_flag_bits  <= 8'h00;
            r_flags_left <= 4'd0;
            r_pair_low   <= 8'h00;
            r_err        <= ST_OK;
            r_cnt        <= 5'd0;
            r_last       <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_seq        <= n_seq;
            r_phase      <= n_phase;
            r_arc        <= n_arc;
            r_orig       <= n_orig;
            r_bytes_in   <= n_bytes_in;
            r_bytes_out  <= n_bytes_out;
            r_flag_bits  <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_pair_low   <= n_pair_low;
            r_err        <= n_err;
            r_cnt        <= n_cnt;
            r_last       <= n_last;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist     <= n_dist;
        r_m_byte   <= n_m_byte;
        r_m_flag   <= n_m_flag;
        r_m_last   <= n_m_last;
        r_m_status <= n_m_status;
    end

    lzss_hist u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_bytes_out[HIST_AW-1:0]),
        .i_wdata (hist_wdata),
        .i_re    (hist_re),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_byte;
    assign m_axis_tuser  = {r_m_status, r_m_flag};
    assign m_axis_tlast  = r_m_last;

    a_copy_in_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SQ_IDLE) |-> (r_phase == PH_PAIR && r_cnt != 5'd0))
        else $error("copy running outside a pair token");

    a_copy_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_READ) |-> (SW'(r_dist) <= r_bytes_out))
        else $error("copy reaches before start of output");

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_out <= r_orig)
        else $error("output count passed original size");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && ld_last) |=> (r_phase == PH_HEADER && r_bytes_in == '0 && r_seq == SQ_IDLE))
        else $error("stream state not cleared after end result");

endmodule

### bench/tb_top.sv
// Self-checking bench for the LZSS stream decompressor: directed and random compressed streams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lzss_pkg::*;

    localparam int SW          = 32;
    localparam int RANDOM_ITEMS = 140;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int N_DIR       = 28;

    typedef struct packed {
        t_byte   data;
        logic    valid;
        logic    fin;
        t_status status;
    } t_out_item;

    typedef struct packed {
        t_byte   data;
        logic    last;
        logic    typed;
        t_status status;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    t_byte      s_axis_tdata = '0;   // in_byte
    logic       s_axis_tlast = 1'b0; // in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    t_byte      m_axis_tdata;        // out_byte
    logic [3:0] m_axis_tuser;        // out_valid, status[2:0]
    logic       m_axis_tlast;        // stream_end

    logic    item_typed = 1'b0;
    t_status item_status = ST_OK;
    logic    calm = 1'b0;
    logic    hold_req = 1'b0;
    logic    hold_done = 1'b0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    int items_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int streams_done = 0;
    int status_seen [8];

    t_byte stream_q[$];
    t_out_item pending_out[$];

    t_byte         hist_mem [HIST_DEPTH];
    t_phase        dec_phase;
    logic [31:0]   arc_acc, orig_acc;
    logic [SW-1:0] arc_len, orig_len, in_count, out_count;
    logic [7:0]    flag_reg;
    int            flags_left;
    t_byte         pair_lo;
    t_status       err_code;

    t_row directed_rows [N_DIR] = '{
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'h80, 1'b1, 1'b1, ST_HDR_SHORT},
        '{8'h0F, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h14, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h03, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'h1F, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b1, 1'b1, ST_OUT_SIZE},
        '{8'h0B, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b1, 1'b1, ST_BAD_REF}
    };

    lzss_stream_decompressor #(.SIZE_WIDTH(SW)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic reset_decoder();
        dec_phase  = PH_HEADER;
        arc_acc    = '0;
        orig_acc   = '0;
        arc_len    = '0;
        orig_len   = '0;
        in_count   = '0;
        out_count  = '0;
        flag_reg   = '0;
        flags_left = 0;
        pair_lo    = '0;
        err_code   = ST_OK;
    endtask

    task automatic emit_byte(input t_byte b);
        hist_mem[t_hist_addr'(out_count)] = b;
        out_count = out_count + 1'b1;
        pending_out.push_back('{b, 1'b1, 1'b0, ST_OK});
    endtask

    task automatic close_token();
        flag_reg = flag_reg >> 1;
        if (flags_left > 0) flags_left--;
        if (out_count >= orig_len) dec_phase = PH_DONE;
        else if (flags_left == 0) dec_phase = PH_FLAG;
        else dec_phase = PH_TOKEN;
    endtask

    task automatic decode_item(input t_byte b, input logic fin_in, input logic typed,
                               input t_status typed_st);
        int unsigned first;
        int unsigned len;
        logic [15:0] word;
        logic [11:0] back_off;
        logic [2:0]  hdr_idx;
        t_byte       v;
        t_status     st;
        first = pending_out.size();
        if (in_count != {SW{1'b1}}) in_count = in_count + 1'b1;
        case (dec_phase)
            PH_HEADER: begin
                hdr_idx = 3'(in_count - 1'b1);
                if (hdr_idx < 3'd4) arc_acc[8*hdr_idx[1:0] +: 8] = b;
                else orig_acc[8*hdr_idx[1:0] +: 8] = b;
                if (hdr_idx == 3'd7) begin
                    arc_len   = arc_acc[SW-1:0];
                    orig_len  = orig_acc[SW-1:0];
                    dec_phase = (orig_len == 0) ? PH_DONE : PH_FLAG;
                end
            end
            PH_FLAG: begin
                flag_reg   = b;
                flags_left = FLAG_COUNT;
                dec_phase  = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (flag_reg[0]) begin
                    emit_byte(b);
                    close_token();
                end else begin
                    pair_lo   = b;
                    dec_phase = PH_PAIR;
                end
            end
            PH_PAIR: begin
                word     = {b, pair_lo};
                len      = LEN_BIAS + word[3:0];
                back_off = word[15:4];
                if (back_off > out_count) begin
                    err_code  = ST_BAD_REF;
                    dec_phase = PH_DONE;
                end else begin
                    for (int k = 0; k < len; k++) begin
                        if (out_count >= orig_len) begin
                            err_code = ST_OUT_SIZE;
                            break;
                        end
                        v = (back_off == 0) ? 8'h00
                                            : hist_mem[t_hist_addr'(out_count - back_off)];
                        emit_byte(v);
                    end
                    close_token();
                end
            end
            default: ;
        endcase
        if (fin_in) begin
            if (dec_phase == PH_HEADER) st = ST_HDR_SHORT;
            else if (arc_len != in_count) st = ST_ARC_SIZE;
            else if (err_code != ST_OK) st = err_code;
            else if (out_count != orig_len) st = ST_OUT_SIZE;
            else st = ST_OK;
            if (typed) st = typed_st;
            if (pending_out.size() == first) pending_out.push_back('{8'h00, 1'b0, 1'b0, ST_OK});
            pending_out[pending_out.size()-1].fin = 1'b1;
            pending_out[pending_out.size()-1].status = st;
            reset_decoder();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                decode_item(s_axis_tdata, s_axis_tlast, item_typed, item_status);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, t_status'(m_axis_tuser[3:1])};
                results_seen++;
                if (got.fin) status_seen[got.status]++;
                if (pending_out.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item byte=%02h valid=%0b end=%0b status=%0d",
                             $time, got.data, got.valid, got.fin, got.status);
                end else begin
                    want = pending_out.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: expected byte=%02h valid=%0b end=%0b status=%0d, %s",
                                 $time, want.data, want.valid, want.fin, want.status,
                                 $sformatf("actual byte=%02h valid=%0b end=%0b status=%0d",
                                           got.data, got.valid, got.fin, got.status));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input t_byte b, input logic fin, input logic typed,
                             input t_status st);
        while (!calm && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        item_typed    <= typed;
        item_status   <= st;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (fin) streams_done++;
    endtask

    task automatic build_stream(input bit clean);
        int unsigned kind, target, made, flag_at, len, back_off, cut;
        logic [31:0] arc_v, orig_v;
        logic [7:0]  flags;
        bit          bad_done;
        t_byte       body[$];
        kind = clean ? 0 : $urandom_range(99);
        bad_done = 1'b0;
        made = 0;
        stream_q.delete();
        if (kind >= 80 && kind < 88) begin
            repeat ($urandom_range(7, 1)) stream_q.push_back(t_byte'($urandom));
        end else begin
            target = (kind >= 70 && kind < 80) ? 0 : $urandom_range(40, 1);
            while (made < target && !bad_done) begin
                flag_at = body.size();
                body.push_back(8'h00);
                flags = 8'h00;
                for (int t = 0; t < 8 && made < target && !bad_done; t++) begin
                    if ($urandom_range(99) < 45) begin
                        flags[t] = 1'b1;
                        body.push_back(t_byte'($urandom));
                        made++;
                    end else begin
                        len = $urandom_range(17, 2);
                        if ($urandom_range(99) < 75 && len > target - made)
                            len = (target - made < 2) ? 2 : target - made;
                        back_off = $urandom_range(made, 0);
                        if (kind >= 88 && kind < 96 && $urandom_range(3) == 0) begin
                            back_off = $urandom_range(4095, made + 1);
                            bad_done = 1'b1;
                        end
                        body.push_back({back_off[3:0], 4'(len - LEN_BIAS)});
                        body.push_back(t_byte'(back_off >> 4));
                        made += len;
                    end
                end
                body[flag_at] = flags;
            end
            if (target == 0 || $urandom_range(99) < 10)
                repeat ($urandom_range(3, 0)) body.push_back(t_byte'($urandom));
            if (kind >= 96 && body.size() > 1) begin
                cut = $urandom_range(body.size() - 1, 1);
                repeat (cut) void'(body.pop_back());
            end
            arc_v  = body.size() + 8;
            orig_v = target;
            if (!clean && $urandom_range(99) < 10)
                arc_v = ($urandom_range(1) == 0) ? $urandom : arc_v - 1;
            if (!clean && $urandom_range(99) < 5) orig_v = $urandom;
            for (int k = 0; k < 4; k++) stream_q.push_back(arc_v[8*k +: 8]);
            for (int k = 0; k < 4; k++) stream_q.push_back(orig_v[8*k +: 8]);
            foreach (body[i]) stream_q.push_back(body[i]);
        end
    endtask

    initial begin
        int n_random;
        n_random = 0;
        reset_decoder();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].status);

        while (items_sent < N_DIR + RANDOM_ITEMS) begin
            build_stream(n_random < 8);
            if (n_random == 2) hold_req <= 1'b1;
            calm <= (n_random >= 5 && n_random < 8);
            foreach (stream_q[i])
                send_item(stream_q[i], i == stream_q.size() - 1, 1'b0, ST_OK);
            if (n_random == 4) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_out.size() != 0) @(posedge i_clk);
            end
            n_random++;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d compressed items in %0d streams, checked %0d output items",
                 items_sent, streams_done, results_seen);
        $display("Stream endings: ok %0d, short header %0d, archive size %0d, bad ref %0d, %s",
                 status_seen[ST_OK], status_seen[ST_HDR_SHORT], status_seen[ST_ARC_SIZE],
                 status_seen[ST_BAD_REF],
                 $sformatf("output size %0d", status_seen[ST_OUT_SIZE]));
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
